FILE: sv/sa_pkg.sv
package sa_pkg;

  localparam int SIZE_W = 20;
  localparam int CAP_W  = 21;
  localparam int BYTE_W = 32;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2
  } sa_cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_MISMATCH = 2'd3
  } sa_status_t;

  // One stack entry: block size and fallback mark.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              fallback;
  } sa_entry_t;

  // Shift control broadcast along the cell row.
  typedef struct packed {
    logic push;
    logic pop;
  } sa_shift_t;

endpackage

FILE: sv/stack_arena_allocator_top.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | command, size, free_offset
// out_    | output    | out_valid/out_stall| offset, fallback, status, bytes_in_use,
//         |           |                    | peak_bytes, grow_advised
// cfg_    | input     | cfg_valid/cfg_ready| arena_capacity
//
// Rate: one item per clock while in_stall is low; the result is loaded into the output
//   register in the cycle after acceptance, together with the update of the top cell
//   and the counters.
// Reset: synchronous active low; clears counters, capacity to 65536, output empty.
//   Entry cells are not cleared, they are only read after being written.
// Stalls: in_stall rises only while a result waits and out_stall is high.
module stack_arena_allocator_top #(
  parameter int ENTRY_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic [sa_pkg::SIZE_W-1:0]   in_size,
  input  logic [sa_pkg::SIZE_W-1:0]   in_free_offset,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sa_pkg::SIZE_W-1:0]   out_offset,
  output logic                        out_fallback,
  output logic [1:0]                  out_status,
  output logic [sa_pkg::BYTE_W-1:0]   out_bytes_in_use,
  output logic [sa_pkg::BYTE_W-1:0]   out_peak_bytes,
  output logic                        out_grow_advised,

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sa_pkg::CAP_W-1:0]    cfg_arena_capacity
);

  localparam int CNT_BITS = $clog2(ENTRY_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(ENTRY_DEPTH);
  localparam logic [sa_pkg::CAP_W-1:0] CAP_RESET = sa_pkg::CAP_W'(65536);

  // Architectural state
  logic [sa_pkg::CAP_W-1:0]  cap_r;
  logic [sa_pkg::CAP_W-1:0]  top_r, top_nxt;
  logic [CNT_BITS-1:0]       count_r, count_nxt;
  logic [sa_pkg::BYTE_W-1:0] live_r, live_nxt;
  logic [sa_pkg::BYTE_W-1:0] peak_r, peak_nxt;

  // Output register
  logic                       out_valid_r;
  logic [sa_pkg::SIZE_W-1:0]  offset_r, offset_nxt;
  logic                       fallback_r, fallback_nxt;
  sa_pkg::sa_status_t         status_r, status_nxt;
  logic                       grow_r, grow_nxt;

  logic                       accept;
  sa_pkg::sa_shift_t          shift;
  sa_pkg::sa_entry_t          push_entry;
  sa_pkg::sa_entry_t          top_entry;

  logic [sa_pkg::CAP_W:0]     alloc_sum;
  logic                       fits;
  logic [sa_pkg::BYTE_W:0]    live_add;
  logic [sa_pkg::CAP_W-1:0]   top_less;
  logic                       bad_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;

  // Allocation fit check: top plus request against capacity, one bit of headroom.
  assign alloc_sum = {1'b0, top_r} + {2'b00, in_size};
  assign fits      = alloc_sum <= {1'b0, cap_r};
  assign live_add  = {1'b0, live_r} + {{(sa_pkg::BYTE_W - sa_pkg::SIZE_W + 1){1'b0}}, in_size};

  // Free check against the newest entry held in cell 0
  assign top_less = top_r - {1'b0, top_entry.size};
  assign bad_free = (top_entry.size != in_size) ||
                    (!top_entry.fallback &&
                     ((top_r < {1'b0, top_entry.size}) || (top_less != {1'b0, in_free_offset})));

  assign push_entry.size     = in_size;
  assign push_entry.fallback = ~fits;

  always_comb begin
    top_nxt      = top_r;
    count_nxt    = count_r;
    live_nxt     = live_r;
    peak_nxt     = peak_r;
    offset_nxt   = '0;
    fallback_nxt = 1'b0;
    status_nxt   = sa_pkg::ST_OK;
    shift        = '0;

    unique case (sa_pkg::sa_cmd_t'(in_command))
      sa_pkg::CMD_ALLOC: begin
        if (count_r == FULL_COUNT) begin
          status_nxt = sa_pkg::ST_FULL;
        end else begin
          shift.push = accept;
          if (fits) begin
            offset_nxt = top_r[sa_pkg::SIZE_W-1:0];
            top_nxt    = alloc_sum[sa_pkg::CAP_W-1:0];
          end else begin
            fallback_nxt = 1'b1;
          end
          count_nxt = count_r + CNT_BITS'(1);
          // saturate the live byte total
          live_nxt  = live_add[sa_pkg::BYTE_W] ? '1 : live_add[sa_pkg::BYTE_W-1:0];
          if (live_nxt > peak_r) begin
            peak_nxt = live_nxt;
          end
        end
      end
      sa_pkg::CMD_FREE: begin
        if (count_r == '0) begin
          status_nxt = sa_pkg::ST_EMPTY;
        end else if (bad_free) begin
          status_nxt = sa_pkg::ST_MISMATCH;
        end else begin
          shift.pop = accept;
          if (!top_entry.fallback) begin
            top_nxt = top_less;
          end
          live_nxt  = (live_r >= {12'd0, top_entry.size}) ?
                      live_r - {12'd0, top_entry.size} : '0;
          count_nxt = count_r - CNT_BITS'(1);
        end
      end
      sa_pkg::CMD_CLEAR: begin
        top_nxt   = '0;
        count_nxt = '0;
        live_nxt  = '0;
        peak_nxt  = '0;
      end
      default: begin
        // unused command: no change, ok status
      end
    endcase

    grow_nxt = peak_nxt >= {{(sa_pkg::BYTE_W - sa_pkg::CAP_W){1'b0}}, cap_r};
  end

  sa_chain #(
    .ENTRY_DEPTH (ENTRY_DEPTH)
  ) u_chain (
    .clk        (clk),
    .shift      (shift),
    .push_entry (push_entry),
    .top_entry  (top_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      top_r       <= '0;
      count_r     <= '0;
      live_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_arena_capacity;
      end
      if (accept) begin
        top_r       <= top_nxt;
        count_r     <= count_nxt;
        live_r      <= live_nxt;
        peak_r      <= peak_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      offset_r   <= offset_nxt;
      fallback_r <= fallback_nxt;
      status_r   <= status_nxt;
      grow_r     <= grow_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_offset       = offset_r;
  assign out_fallback     = fallback_r;
  assign out_status       = status_r;
  assign out_bytes_in_use = live_r;
  assign out_peak_bytes   = peak_r;
  assign out_grow_advised = grow_r;

  // Stack depth never exceeds the cell row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count beyond depth");

  // Peak tracks the live total from above
  a_peak_ge_live: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= live_r)
    else $error("peak below live bytes");

  // An empty stack holds no arena bytes
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (top_r == '0))
    else $error("top nonzero with empty stack");

  // Clear empties the count, live and peak totals on the next cycle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == sa_pkg::CMD_CLEAR)) |=>
      (count_r == '0 && live_r == '0 && peak_r == '0))
    else $error("clear did not empty state");

  // Cells shift only on an accepted item, never pushing and popping together
  a_shift_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (shift.push || shift.pop) |-> (accept && !(shift.push && shift.pop)))
    else $error("stray cell shift");

endmodule

FILE: sv/sa_cell.sv
module sa_cell (
  input  logic              clk,
  input  sa_pkg::sa_shift_t shift,
  input  sa_pkg::sa_entry_t from_up,
  input  sa_pkg::sa_entry_t from_down,
  output sa_pkg::sa_entry_t entry
);

  sa_pkg::sa_entry_t entry_r;
  sa_pkg::sa_entry_t entry_nxt;

  // push moves entries away from the top, pop pulls them back
  always_comb begin
    entry_nxt = entry_r;
    if (shift.push) begin
      entry_nxt = from_up;
    end else if (shift.pop) begin
      entry_nxt = from_down;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

FILE: sv/sa_chain.sv
module sa_chain #(
  parameter int ENTRY_DEPTH = 32
) (
  input  logic              clk,
  input  sa_pkg::sa_shift_t shift,
  input  sa_pkg::sa_entry_t push_entry,
  output sa_pkg::sa_entry_t top_entry
);

  sa_pkg::sa_entry_t cell_q [ENTRY_DEPTH];

  for (genvar i = 0; i < ENTRY_DEPTH; i++) begin : g_cell
    sa_pkg::sa_entry_t up_d;
    sa_pkg::sa_entry_t down_d;

    if (i == 0) begin : g_first
      assign up_d = push_entry;
    end else begin : g_mid
      assign up_d = cell_q[i-1];
    end

    if (i == ENTRY_DEPTH - 1) begin : g_last
      assign down_d = '0;
    end else begin : g_inner
      assign down_d = cell_q[i+1];
    end

    sa_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .from_up   (up_d),
      .from_down (down_d),
      .entry     (cell_q[i])
    );
  end

  // cell 0 always holds the newest entry
  assign top_entry = cell_q[0];

endmodule
